>>> rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; every other file of the block refers to it by scoped names.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_LEN   = COLUMNS * (ROWS - 1);

  localparam int POS_W  = 11;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CELL_W = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [7:0]        NEWLINE_CODE = 8'd10;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    K_NOP  = 2'd0,
    K_PUT  = 2'd1,
    K_READ = 2'd2
  } kind_t;

  // One classified request as the back end executes it.
  typedef struct packed {
    kind_t              kind;
    logic               scroll;
    logic [ADDR_W-1:0]  addr;
    logic [CELL_W-1:0]  cell_word;
    logic [POS_W-1:0]   cursor;
  } cmd_t;

  // Queue occupancy as seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/core/tcw_front.sv
// Front end of the text console writer: accepts requests, tracks the cursor
// and turns each request into a command for the queue. Depends on tcw_pkg.
module tcw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [7:0]                 in_char_code,
  input  logic [3:0]                 in_back_color,
  input  logic [3:0]                 in_fore_color,
  input  logic [10:0]                in_cell_index,
  input  logic                       back_ready,
  input  tcw_pkg::qstat_t            qstat,
  output logic                       push,
  output tcw_pkg::cmd_t              push_cmd
);

  localparam logic [tcw_pkg::POS_W-1:0] CELLS_P  = tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT);
  localparam logic [tcw_pkg::POS_W-1:0] BOTTOM_P = tcw_pkg::POS_W'(tcw_pkg::COPY_LEN);
  localparam logic [tcw_pkg::POS_W-1:0] COLS_P   = tcw_pkg::POS_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

  // pos_r is the write position; lrow_r and lcol_r locate the cell just
  // before it, which is what a newline looks at.
  logic [tcw_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [tcw_pkg::ROW_W-1:0] lrow_r, lrow_nxt;
  logic [tcw_pkg::COL_W-1:0] lcol_r, lcol_nxt;
  logic [tcw_pkg::POS_W-1:0] row_plus1;

  assign in_ready = back_ready && !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    pos_nxt   = pos_r;
    lrow_nxt  = lrow_r;
    lcol_nxt  = lcol_r;
    row_plus1 = tcw_pkg::POS_W'(lrow_r) + tcw_pkg::POS_W'(1);
    push_cmd.kind      = tcw_pkg::K_NOP;
    push_cmd.scroll    = 1'b0;
    push_cmd.addr      = in_cell_index[tcw_pkg::ADDR_W-1:0];
    push_cmd.cell_word = {in_back_color, in_fore_color, in_char_code};
    if (in_op == tcw_pkg::OP_READ) begin
      if (in_cell_index < tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT)) begin
        push_cmd.kind = tcw_pkg::K_READ;
      end
    end else if (in_char_code == tcw_pkg::NEWLINE_CODE) begin
      pos_nxt  = row_plus1 * COLS_P;
      lcol_nxt = LAST_COL;
    end else begin
      push_cmd.kind = tcw_pkg::K_PUT;
      if (pos_r >= CELLS_P) begin
        push_cmd.scroll = 1'b1;
        push_cmd.addr   = BOTTOM_P[tcw_pkg::ADDR_W-1:0];
        pos_nxt         = BOTTOM_P + tcw_pkg::POS_W'(1);
        lrow_nxt        = LAST_ROW;
        lcol_nxt        = '0;
      end else begin
        push_cmd.addr = pos_r[tcw_pkg::ADDR_W-1:0];
        pos_nxt       = pos_r + tcw_pkg::POS_W'(1);
        if (pos_r == '0) begin
          lrow_nxt = '0;
          lcol_nxt = '0;
        end else if (lcol_r == LAST_COL) begin
          lrow_nxt = lrow_r + tcw_pkg::ROW_W'(1);
          lcol_nxt = '0;
        end else begin
          lcol_nxt = lcol_r + tcw_pkg::COL_W'(1);
        end
      end
    end
    push_cmd.cursor = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lrow_r <= '0;
      lcol_r <= '0;
    end else if (push) begin
      pos_r  <= pos_nxt;
      lrow_r <= lrow_nxt;
      lcol_r <= lcol_nxt;
    end
  end

endmodule

>>> rtl/core/tcw_fifo.sv
// Short command queue between the front and back ends of the console writer.
// Depends on tcw_pkg for the command type and the queue depth.
module tcw_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcw_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output tcw_pkg::cmd_t   head,
  output tcw_pkg::qstat_t qstat
);

  tcw_pkg::cmd_t              entry_r [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [tcw_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign head        = entry_r[rp_r];
  assign qstat.full  = (cnt_r == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (tcw_pkg::QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (tcw_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + tcw_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/tcw_back.sv
// Back end of the console writer: owns the screen memory, clears it after
// reset, executes queued commands including the row-copy scroll, and holds
// the result register. Depends on tcw_pkg.
module tcw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_pkg::cmd_t         head,
  input  tcw_pkg::qstat_t       qstat,
  output logic                  pop,
  output logic                  back_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_cell_data,
  output logic [10:0]           out_cursor_pos,
  output logic                  out_scrolled
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;

  localparam logic [tcw_pkg::POS_W-1:0] LAST_P = tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::POS_W-1:0] COPY_P = tcw_pkg::POS_W'(tcw_pkg::COPY_LEN);
  localparam logic [tcw_pkg::POS_W-1:0] COLS_P = tcw_pkg::POS_W'(tcw_pkg::COLUMNS);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] mem_q_r;

  logic [2:0]                  state_r, state_nxt;
  logic [tcw_pkg::POS_W-1:0]   cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [tcw_pkg::ADDR_W-1:0]  dst_r, dst_nxt;
  tcw_pkg::cmd_t               cmd_r, cmd_nxt;

  logic                        mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;

  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0]  out_data_r;
  logic [tcw_pkg::POS_W-1:0]   out_cursor_r;
  logic                        out_scroll_r;
  logic                        load_out;
  logic [tcw_pkg::CELL_W-1:0]  ld_data;
  logic [tcw_pkg::POS_W-1:0]   ld_cursor;
  logic                        ld_scroll;

  assign back_ready     = (state_r != S_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_scrolled   = out_scroll_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    dst_nxt   = dst_r;
    cmd_nxt   = cmd_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[tcw_pkg::ADDR_W-1:0];
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = head.addr;
    load_out  = 1'b0;
    ld_data   = '0;
    ld_cursor = cmd_r.cursor;
    ld_scroll = cmd_r.scroll;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_P) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + tcw_pkg::POS_W'(1);
        end
      end
      S_IDLE: begin
        // The result slot is empty for the whole of a command's execution.
        if (!qstat.empty && !out_valid_r) begin
          pop       = 1'b1;
          cmd_nxt   = head;
          ld_cursor = head.cursor;
          ld_scroll = head.scroll;
          case (head.kind)
            tcw_pkg::K_READ: begin
              mem_re    = 1'b1;
              state_nxt = S_READ;
            end
            tcw_pkg::K_PUT: begin
              if (head.scroll) begin
                cnt_nxt   = '0;
                state_nxt = S_COPY;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head.addr;
                mem_wdata = head.cell_word;
                load_out  = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load_out  = 1'b1;
        ld_data   = mem_q_r;
        state_nxt = S_IDLE;
      end
      S_COPY: begin
        // Read one row below, write the registered word in the next cycle.
        mem_we    = pend_r;
        mem_waddr = dst_r;
        mem_wdata = mem_q_r;
        if (cnt_r < COPY_P) begin
          mem_re    = 1'b1;
          mem_raddr = tcw_pkg::ADDR_W'(cnt_r + COLS_P);
          pend_nxt  = 1'b1;
          dst_nxt   = cnt_r[tcw_pkg::ADDR_W-1:0];
          cnt_nxt   = cnt_r + tcw_pkg::POS_W'(1);
        end else begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        // The first cell of the bottom row takes the new character.
        mem_we = 1'b1;
        if (cnt_r == COPY_P) begin
          mem_wdata = cmd_r.cell_word;
        end
        if (cnt_r == LAST_P) begin
          load_out  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + tcw_pkg::POS_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    dst_r <= dst_nxt;
    if (load_out) begin
      out_data_r   <= ld_data;
      out_cursor_r <= ld_cursor;
      out_scroll_r <= ld_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/text_console_writer.sv
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   op, char_code, back_color, fore_color, cell_index
//   out_      output     out_valid / out_ready cell_data, cursor_pos, scrolled
//
// After reset the screen memory is cleared one cell per cycle, all CELL_COUNT (2000)
// cells, while in_ready stays low.
// A read passes through S_READ for the registered memory read; a put that does not
// scroll and a newline finish in S_IDLE.
// In a put that scrolls, the row copy moves one cell per cycle through the memory,
// then the bottom row is blanked.
// The queue accepts requests while the back end is busy or out_ready is low, until its QDEPTH (4) entries are full.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_back_color,
  input  logic [3:0]  in_fore_color,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_data,
  output logic [10:0] out_cursor_pos,
  output logic        out_scrolled
);

  logic            back_ready;
  logic            push, pop;
  tcw_pkg::cmd_t   push_cmd, head;
  tcw_pkg::qstat_t qstat;

  tcw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_char_code  (in_char_code),
    .in_back_color (in_back_color),
    .in_fore_color (in_fore_color),
    .in_cell_index (in_cell_index),
    .back_ready    (back_ready),
    .qstat         (qstat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tcw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .back_ready     (back_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_data  (out_cell_data),
    .out_cursor_pos (out_cursor_pos),
    .out_scrolled   (out_scrolled)
  );

endmodule

>>> rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_cell_data,
  input logic [10:0] out_cursor_pos,
  input logic        out_scrolled
);

  localparam logic [10:0] CELLS_P  = 11'(tcw_pkg::CELL_COUNT);
  localparam logic [10:0] SCROLL_P = 11'(tcw_pkg::COPY_LEN + 1);

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_data)
      && $stable(out_cursor_pos) && $stable(out_scrolled))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_pos <= CELLS_P)
    else $error("cursor beyond one past the last cell");

  // A scrolling put always leaves the cursor just past the first cell of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_pos == SCROLL_P)
    else $error("scroll left the cursor off the bottom row");

  a_scroll_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cell_data == 16'h0000)
    else $error("scroll result carries cell data");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cell_data  (out_cell_data),
  .out_cursor_pos (out_cursor_pos),
  .out_scrolled   (out_scrolled)
);
